FILE: rtl/zero_padded_2d_convolution_macros.svh
`ifndef ZERO_PADDED_2D_CONVOLUTION_MACROS_SVH
`define ZERO_PADDED_2D_CONVOLUTION_MACROS_SVH

// same-cycle implication, checked outside reset
`define ZPC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ZPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/zpc_pkg.sv
`default_nettype none
package zpc_pkg;
   localparam int MAX_MASK   = 7;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int TAP_DEPTH  = MAX_MASK * MAX_MASK;
   localparam int LINE_DEPTH = (MAX_MASK - 1) * MAX_WIDTH + MAX_MASK;
   localparam int TAP_AW     = $clog2(TAP_DEPTH);
   localparam int LINE_AW    = $clog2(LINE_DEPTH);
   localparam int POS_W      = $clog2((MAX_HEIGHT + MAX_MASK) * MAX_WIDTH + MAX_MASK);
   localparam int MASK_LIM   = ((MAX_MASK - 1) | 1) > MAX_MASK ? ((MAX_MASK - 1) | 1) - 2
                                                               : ((MAX_MASK - 1) | 1);

   localparam logic [1:0] FUNC_TAP = 2'd0;
   localparam logic [1:0] FUNC_PIX = 2'd1;
   localparam logic [1:0] FUNC_PAD = 2'd2;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_MASK   = 2'd2;

   typedef struct packed {
      logic               en;
      logic [5:0]         idx;
      logic signed [15:0] val;
   } tap_wr_type;
endpackage
`default_nettype wire

FILE: rtl/zpc_taps.sv
`default_nettype none
`include "zero_padded_2d_convolution_macros.svh"
module zpc_taps
   import zpc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tap_wr_type         wr,
   input  wire logic [TAP_AW-1:0]  rd_idx,
   output logic signed [15:0]      rd_data
);
   logic signed [15:0]  tap_mem [0:TAP_DEPTH-1];
   logic [TAP_DEPTH-1:0] valid_ff;
   logic signed [15:0]  rd_raw_ff;
   logic                rd_ok_ff;
   logic                wr_hit;

   assign wr_hit = wr.en && (wr.idx < 6'(TAP_DEPTH));

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         tap_mem[wr.idx[TAP_AW-1:0]] <= wr.val;
      end
      rd_raw_ff <= tap_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (wr_hit) valid_ff[wr.idx[TAP_AW-1:0]] <= 1'b1;
         rd_ok_ff <= valid_ff[rd_idx];
      end
   end

   assign rd_data = rd_ok_ff ? rd_raw_ff : 16'sd0;

   `ZPC_ASSERT_NEXT(a_tap_valid, clock, reset, wr_hit, valid_ff[$past(wr.idx[TAP_AW-1:0])], "tap write lost")
   `ZPC_ASSERT_NOW(a_rd_range, clock, reset, 1'b1, rd_idx < TAP_AW'(TAP_DEPTH), "tap read out of range")
   `ZPC_ASSERT_NEXT(a_rd_zero, clock, reset, !valid_ff[rd_idx], rd_data == 16'sd0, "unwritten tap not zero")
endmodule
`default_nettype wire

FILE: rtl/zero_padded_2d_convolution.sv
`default_nettype none
// A pixel that completes a window runs a pass over the m*m taps (S_RUN, S_DRAIN), then
// S_OUT registers its word, waiting while rsp_tready is low. No request is taken meanwhile;
// taps and lead pixels need no pass. The rate is set by the single read port of the line memory.
// Reset is synchronous: taps read as zero, frame position clears, registers return to
// width 1, height 1, mask 3. The line memory needs no clearing pass.
`include "zero_padded_2d_convolution_macros.svh"
module zero_padded_2d_convolution
   import zpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // func[1:0] coef_index[7:2] coef_value[23:8] pixel[31:24]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // filtered_value[31:0]
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [10:0] csr_wdata
);
   typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_OUT} state_type;

   state_type state_ff, state_in;
   logic [10:0] width_ff, width_in, height_ff, height_in;
   logic [2:0]  mask_ff, mask_in;
   logic        hold_ff, hold_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [LINE_AW-1:0] wa_ff, wa_in, cur_ff, cur_in;
   logic [9:0]  orow_ff, orow_in, ocol_ff, ocol_in;
   logic [2:0]  i_ff, i_in, j_ff, j_in;
   logic [TAP_AW-1:0]  tidx_ff, tidx_in;
   logic [LINE_AW-1:0] rowb_ff, rowb_in;
   logic [2:0]  colb_ff, colb_in;
   logic        cnt_ff, cnt_in;
   logic        rv_ff, pv_ff;
   logic        use_ff;
   logic [7:0]  pix_ff;
   logic signed [24:0] prod_ff;
   logic signed [33:0] acc_ff;
   logic        rvalid_ff, rvalid_in, rlast_ff, rlast_in;
   logic [31:0] rdata_ff, rdata_in;

   logic [POS_W-1:0]   total_ff, lead_ff, leadtot_ff;
   logic [LINE_AW-1:0] rowb0_ff;

   logic [10:0] w_eff, h_eff;
   logic [2:0]  m_eff, add, add2;
   logic        accept, pix_item, acc_clr, issue, last_tap;
   logic [1:0]  func;
   logic [LINE_AW-1:0] back, rd_addr;
   logic [10:0] trow, tcol;
   logic        use_now;
   logic [7:0]  line_wd;
   logic signed [33:0] acc_sat_hi;
   logic [31:0] sat_val;
   logic        frame_end;
   tap_wr_type  tap_wr;
   logic signed [15:0] tap_rd;
   logic [7:0]  line_mem [0:LINE_DEPTH-1];

   always_comb begin
      if (width_ff == 11'd0) w_eff = 11'd1;
      else if (width_ff > 11'(MAX_WIDTH)) w_eff = 11'(MAX_WIDTH);
      else w_eff = width_ff;
      if (height_ff == 11'd0) h_eff = 11'd1;
      else if (height_ff > 11'(MAX_HEIGHT)) h_eff = 11'(MAX_HEIGHT);
      else h_eff = height_ff;
      m_eff = mask_ff | 3'd1;
      if (m_eff > 3'(MASK_LIM)) m_eff = 3'(MASK_LIM);
      add  = m_eff >> 1;
      add2 = add << 1;
   end

   always_ff @(posedge clock) begin
      total_ff   <= POS_W'(w_eff) * POS_W'(h_eff);
      lead_ff    <= POS_W'(add) * POS_W'(w_eff) + POS_W'(add);
      leadtot_ff <= POS_W'(w_eff) * POS_W'(h_eff) + POS_W'(add) * POS_W'(w_eff) + POS_W'(add);
      rowb0_ff   <= LINE_AW'(add2) * LINE_AW'(w_eff);
   end

   assign func     = req_tdata[1:0];
   assign req_tready = (state_ff == S_IDLE) && !hold_ff;
   assign accept   = req_tvalid && req_tready;
   assign pix_item = accept && (func == FUNC_PIX || func == FUNC_PAD);
   assign line_wd  = (func == FUNC_PIX && pos_ff < total_ff) ? req_tdata[31:24] : 8'd0;

   assign tap_wr.en  = accept && (func == FUNC_TAP);
   assign tap_wr.idx = req_tdata[7:2];
   assign tap_wr.val = req_tdata[23:8];

   assign back    = rowb_ff + LINE_AW'(colb_ff);
   assign rd_addr = (cur_ff >= back) ? cur_ff - back
                                     : LINE_AW'(cur_ff + LINE_AW'(LINE_DEPTH) - back);
   assign trow    = 11'(orow_ff) + 11'(i_ff);
   assign tcol    = 11'(ocol_ff) + 11'(j_ff);
   assign use_now = (trow >= 11'(add)) && (12'(trow) < 12'(h_eff) + 12'(add))
                 && (tcol >= 11'(add)) && (12'(tcol) < 12'(w_eff) + 12'(add));
   assign issue    = (state_ff == S_RUN);
   assign last_tap = (i_ff == m_eff - 3'd1) && (j_ff == m_eff - 3'd1);
   assign frame_end = (orow_ff == 10'(h_eff - 11'd1)) && (ocol_ff == 10'(w_eff - 11'd1));

   always_comb begin
      acc_sat_hi = 34'sd2147483647;
      if (acc_ff > acc_sat_hi) sat_val = 32'h7FFF_FFFF;
      else if (acc_ff < -34'sd2147483648) sat_val = 32'h8000_0000;
      else sat_val = acc_ff[31:0];
   end

   always_comb begin
      state_in  = state_ff;
      width_in  = width_ff;
      height_in = height_ff;
      mask_in   = mask_ff;
      hold_in   = 1'b0;
      pos_in    = pos_ff;
      wa_in     = wa_ff;
      cur_in    = cur_ff;
      orow_in   = orow_ff;
      ocol_in   = ocol_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      tidx_in   = tidx_ff;
      rowb_in   = rowb_ff;
      colb_in   = colb_ff;
      cnt_in    = cnt_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      rlast_in  = rlast_ff;
      rdata_in  = rdata_ff;
      acc_clr   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (pix_item) begin
               if (pos_ff >= lead_ff && pos_ff >= leadtot_ff) begin
                  pos_in = '0;
                  wa_in  = '0;
                  orow_in = '0;
                  ocol_in = '0;
               end else begin
                  pos_in = pos_ff + POS_W'(1);
                  wa_in  = (wa_ff == LINE_AW'(LINE_DEPTH - 1)) ? '0 : wa_ff + LINE_AW'(1);
                  if (pos_ff >= lead_ff) begin
                     state_in = S_RUN;
                     cur_in   = wa_ff;
                     i_in     = '0;
                     j_in     = '0;
                     tidx_in  = '0;
                     rowb_in  = rowb0_ff;
                     colb_in  = add2;
                     acc_clr  = 1'b1;
                  end
               end
            end
         end
         S_RUN: begin
            if (last_tap) begin
               state_in = S_DRAIN;
               cnt_in   = 1'b1;
            end else if (j_ff == m_eff - 3'd1) begin
               tidx_in = tidx_ff + TAP_AW'(1);
               j_in    = '0;
               i_in    = i_ff + 3'd1;
               rowb_in = rowb_ff - LINE_AW'(w_eff);
               colb_in = add2;
            end else begin
               tidx_in = tidx_ff + TAP_AW'(1);
               j_in    = j_ff + 3'd1;
               colb_in = colb_ff - 3'd1;
            end
         end
         S_DRAIN: begin
            if (cnt_ff) cnt_in = 1'b0;
            else state_in = S_OUT;
         end
         S_OUT: begin
            if (!rvalid_ff || rsp_tready) begin
               rvalid_in = 1'b1;
               rdata_in  = sat_val;
               rlast_in  = frame_end;
               state_in  = S_IDLE;
               if (frame_end) begin
                  pos_in  = '0;
                  wa_in   = '0;
                  orow_in = '0;
                  ocol_in = '0;
               end else if (ocol_ff == 10'(w_eff - 11'd1)) begin
                  ocol_in = '0;
                  orow_in = orow_ff + 10'd1;
               end else begin
                  ocol_in = ocol_ff + 10'd1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (csr_we) begin
         hold_in = 1'b1;
         if (csr_index <= REG_MASK) begin
            pos_in  = '0;
            wa_in   = '0;
            orow_in = '0;
            ocol_in = '0;
         end
         case (csr_index)
            REG_WIDTH:  width_in  = csr_wdata;
            REG_HEIGHT: height_in = csr_wdata;
            REG_MASK:   mask_in   = csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         width_ff  <= 11'd1;
         height_ff <= 11'd1;
         mask_ff   <= 3'd3;
         hold_ff   <= 1'b1;
         pos_ff    <= '0;
         wa_ff     <= '0;
         orow_ff   <= '0;
         ocol_ff   <= '0;
         cnt_ff    <= 1'b0;
         rv_ff     <= 1'b0;
         pv_ff     <= 1'b0;
         rvalid_ff <= 1'b0;
         i_ff      <= '0;
         j_ff      <= '0;
         tidx_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         mask_ff   <= mask_in;
         hold_ff   <= hold_in;
         pos_ff    <= pos_in;
         wa_ff     <= wa_in;
         orow_ff   <= orow_in;
         ocol_ff   <= ocol_in;
         cnt_ff    <= cnt_in;
         rv_ff     <= issue;
         pv_ff     <= rv_ff;
         rvalid_ff <= rvalid_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         tidx_ff   <= tidx_in;
      end
      cur_ff   <= cur_in;
      rowb_ff  <= rowb_in;
      colb_ff  <= colb_in;
      rlast_ff <= rlast_in;
      rdata_ff <= rdata_in;
      use_ff   <= use_now;
      prod_ff  <= use_ff ? $signed({1'b0, pix_ff}) * tap_rd : 25'sd0;
      if (acc_clr) acc_ff <= '0;
      else if (pv_ff) acc_ff <= acc_ff + 34'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (pix_item) line_mem[wa_ff] <= line_wd;
      pix_ff <= line_mem[rd_addr];
   end

   zpc_taps u_taps (
      .clock   (clock),
      .reset   (reset),
      .wr      (tap_wr),
      .rd_idx  (tidx_ff),
      .rd_data (tap_rd)
   );

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tlast  = rlast_ff;

   `ZPC_ASSERT_NOW(a_no_prod_idle, clock, reset, pv_ff, state_ff == S_DRAIN || state_ff == S_RUN, "product outside window pass")
   `ZPC_ASSERT_NOW(a_tidx_range, clock, reset, state_ff == S_RUN, tidx_ff < TAP_AW'(TAP_DEPTH), "tap index overrun")
   `ZPC_ASSERT_NEXT(a_frame_restart, clock, reset, state_ff == S_OUT && (!rvalid_ff || rsp_tready) && frame_end && !csr_we, pos_ff == '0 && rsp_tlast, "frame did not restart")
endmodule
`default_nettype wire
